// ===== hdl/interval_overlap_histogram_core_defines.svh =====
// Assertion macros shared by the histogram RTL.
`ifndef INTERVAL_OVERLAP_HISTOGRAM_CORE_DEFINES_SVH
`define INTERVAL_OVERLAP_HISTOGRAM_CORE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define IOHIST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen outside reset.
`define IOHIST_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/iohist_pkg.sv =====
package iohist_pkg;

   localparam int NUM_BUCKETS_DEF = 16;
   localparam int COUNT_WIDTH_DEF = 32;

   localparam int OP_W        = 2;
   localparam int INDEX_W     = 4;
   localparam int BOUND_W     = 32;
   localparam int WEIGHT_W    = 32;
   localparam int OUT_COUNT_W = 32;
   localparam int ACTIVE_W    = 5;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_OBSERVE = 2'd1,
      OP_MERGE   = 2'd2,
      OP_READOUT = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   // Per-cycle commands broadcast to every bucket cell.
   typedef struct packed {
      logic load;
      logic observe;
      logic merge;
      logic rotate;
   } cell_ctrl_type;

endpackage

// ===== hdl/iohist_if.sv =====
interface iohist_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [iohist_pkg::OP_W-1:0]            op;
   logic [iohist_pkg::INDEX_W-1:0]         bucket_index;
   logic signed [iohist_pkg::BOUND_W-1:0]  range_low;
   logic signed [iohist_pkg::BOUND_W-1:0]  range_high;
   logic [iohist_pkg::WEIGHT_W-1:0]        weight;
   logic                                   is_null;

   modport source (output valid, op, bucket_index, range_low, range_high, weight, is_null,
                   input ready);
   modport sink (input valid, op, bucket_index, range_low, range_high, weight, is_null,
                 output ready);
endinterface

interface iohist_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [iohist_pkg::INDEX_W-1:0]         out_index;
   logic signed [iohist_pkg::BOUND_W-1:0]  out_low_bound;
   logic signed [iohist_pkg::BOUND_W-1:0]  out_high_bound;
   logic [iohist_pkg::OUT_COUNT_W-1:0]     out_count;
   logic                                   last;

   modport source (output valid, out_index, out_low_bound, out_high_bound, out_count, last,
                   input ready);
   modport sink (input valid, out_index, out_low_bound, out_high_bound, out_count, last,
                 output ready);
endinterface

interface iohist_csr_if;
   logic                                valid;
   logic                                ready;
   logic [iohist_pkg::ACTIVE_W-1:0]     data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== hdl/iohist_cell.sv =====
// One bucket: bounds plus saturating count. On rotate it takes its
// upstream neighbor's contents, so the row turns like a ring.
module iohist_cell #(
   parameter int COUNT_WIDTH = iohist_pkg::COUNT_WIDTH_DEF,
   parameter int CELL_INDEX  = 0,
   parameter int LIM_W       = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  iohist_pkg::cell_ctrl_type              ctrl,
   input  logic [LIM_W-1:0]                       active_lim,
   input  logic [iohist_pkg::INDEX_W-1:0]         bucket_index,
   input  logic signed [iohist_pkg::BOUND_W-1:0]  range_low,
   input  logic signed [iohist_pkg::BOUND_W-1:0]  range_high,
   input  logic [iohist_pkg::WEIGHT_W-1:0]        weight,
   input  logic signed [iohist_pkg::BOUND_W-1:0]  nb_low,
   input  logic signed [iohist_pkg::BOUND_W-1:0]  nb_high,
   input  logic [COUNT_WIDTH-1:0]                 nb_count,
   output logic signed [iohist_pkg::BOUND_W-1:0]  low,
   output logic signed [iohist_pkg::BOUND_W-1:0]  high,
   output logic [COUNT_WIDTH-1:0]                 count
);

   localparam int SUM_W = ((COUNT_WIDTH > iohist_pkg::WEIGHT_W) ?
                           COUNT_WIDTH : iohist_pkg::WEIGHT_W) + 1;

   logic signed [iohist_pkg::BOUND_W-1:0] low_ff, low_in;
   logic signed [iohist_pkg::BOUND_W-1:0] high_ff, high_in;
   logic [COUNT_WIDTH-1:0]                count_ff, count_in;
   logic [SUM_W-1:0]                      sum;
   logic [COUNT_WIDTH-1:0]                sat_sum;
   logic                                  hit;
   logic                                  active;
   logic                                  overlap;

   assign hit     = (32'(bucket_index) == 32'(CELL_INDEX));
   assign active  = (32'(active_lim) > 32'(CELL_INDEX));
   assign overlap = (range_low <= high_ff) && (range_high >= low_ff);

   assign sum     = SUM_W'(count_ff) + SUM_W'(weight);
   assign sat_sum = (sum > SUM_W'({COUNT_WIDTH{1'b1}})) ? {COUNT_WIDTH{1'b1}}
                                                         : sum[COUNT_WIDTH-1:0];

   always_comb begin
      low_in   = low_ff;
      high_in  = high_ff;
      count_in = count_ff;
      if (ctrl.rotate) begin
         low_in   = nb_low;
         high_in  = nb_high;
         count_in = nb_count;
      end else if (ctrl.load && hit) begin
         low_in   = range_low;
         high_in  = range_high;
         count_in = '0;
      end else if ((ctrl.observe && active && overlap) || (ctrl.merge && hit)) begin
         count_in = sat_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff   <= '0;
         high_ff  <= '0;
         count_ff <= '0;
      end else begin
         low_ff   <= low_in;
         high_ff  <= high_in;
         count_ff <= count_in;
      end
   end

   assign low   = low_ff;
   assign high  = high_ff;
   assign count = count_ff;

endmodule

// ===== hdl/interval_overlap_histogram_core.sv =====
// Range-bucket histogram. A row of NUM_BUCKETS bucket cells holds the
// bounds and saturating counts. An observe is tested against all active
// buckets in parallel, so load, observe and merge requests stream at one
// per cycle while no readout is in progress. A readout request turns the
// row as a ring through cell 0, one bucket per cycle, and always makes a
// full turn so the table ends where it started; it emits the first
// active_buckets entries in index order and holds a step that emits while
// the output register is full. No new request is taken during the turn,
// so a readout occupies the block for the full turn plus any output stall.
// The active bucket register is written through the csr port, which is
// always ready.
`include "interval_overlap_histogram_core_defines.svh"

module interval_overlap_histogram_core #(
   parameter int NUM_BUCKETS = iohist_pkg::NUM_BUCKETS_DEF,
   parameter int COUNT_WIDTH = iohist_pkg::COUNT_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   iohist_req_if.sink   req_if,
   iohist_rsp_if.source rsp_if,
   iohist_csr_if.sink   csr_if
);

   localparam int LIM_W = $clog2(NUM_BUCKETS + 1);
   localparam int CNT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int OUTC_W = (COUNT_WIDTH > iohist_pkg::OUT_COUNT_W) ?
                           COUNT_WIDTH : iohist_pkg::OUT_COUNT_W;

   logic signed [iohist_pkg::BOUND_W-1:0] cell_low   [NUM_BUCKETS];
   logic signed [iohist_pkg::BOUND_W-1:0] cell_high  [NUM_BUCKETS];
   logic [COUNT_WIDTH-1:0]                cell_count [NUM_BUCKETS];

   iohist_pkg::state_type           state_ff, state_in;
   logic [CNT_W-1:0]                rot_cnt_ff, rot_cnt_in;
   logic [iohist_pkg::ACTIVE_W-1:0] active_ff, active_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [iohist_pkg::INDEX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic signed [iohist_pkg::BOUND_W-1:0] rsp_low_ff, rsp_low_in;
   logic signed [iohist_pkg::BOUND_W-1:0] rsp_high_ff, rsp_high_in;
   logic [iohist_pkg::OUT_COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                                  rsp_last_ff, rsp_last_in;

   iohist_pkg::cell_ctrl_type ctrl;
   logic [LIM_W-1:0]          active_lim;
   logic                      req_take;
   logic                      emit;
   logic                      step;
   logic                      out_free;
   logic                      turn_done;
   logic [OUTC_W-1:0]         head_count;

   assign active_lim = (32'(active_ff) > 32'(NUM_BUCKETS)) ? LIM_W'(NUM_BUCKETS)
                                                           : LIM_W'(active_ff);

   assign req_if.ready = (state_ff == iohist_pkg::ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign emit      = (32'(rot_cnt_ff) < 32'(active_lim));
   assign step      = (state_ff == iohist_pkg::ST_READ) && (!emit || out_free);
   assign turn_done = (32'(rot_cnt_ff) == 32'(NUM_BUCKETS - 1));

   always_comb begin
      ctrl.load    = req_take && (req_if.op == iohist_pkg::OP_LOAD);
      ctrl.observe = req_take && (req_if.op == iohist_pkg::OP_OBSERVE) && !req_if.is_null;
      ctrl.merge   = req_take && (req_if.op == iohist_pkg::OP_MERGE);
      ctrl.rotate  = step;
   end

   for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
      iohist_cell #(
         .COUNT_WIDTH (COUNT_WIDTH),
         .CELL_INDEX  (i),
         .LIM_W       (LIM_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .active_lim   (active_lim),
         .bucket_index (req_if.bucket_index),
         .range_low    (req_if.range_low),
         .range_high   (req_if.range_high),
         .weight       (req_if.weight),
         .nb_low       (cell_low[(i + 1) % NUM_BUCKETS]),
         .nb_high      (cell_high[(i + 1) % NUM_BUCKETS]),
         .nb_count     (cell_count[(i + 1) % NUM_BUCKETS]),
         .low          (cell_low[i]),
         .high         (cell_high[i]),
         .count        (cell_count[i])
      );
   end

   // wide counts clamp to the 32-bit output field
   assign head_count = OUTC_W'(cell_count[0]);

   always_comb begin
      state_in     = state_ff;
      rot_cnt_in   = rot_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_index_in = rsp_index_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         iohist_pkg::ST_IDLE: begin
            rot_cnt_in = '0;
            if (req_take && (req_if.op == iohist_pkg::OP_READOUT)) begin
               state_in = iohist_pkg::ST_READ;
            end
         end
         iohist_pkg::ST_READ: begin
            if (step) begin
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = iohist_pkg::INDEX_W'(rot_cnt_ff);
                  rsp_low_in   = cell_low[0];
                  rsp_high_in  = cell_high[0];
                  rsp_count_in = (head_count > OUTC_W'(32'hFFFF_FFFF)) ? '1
                                 : head_count[iohist_pkg::OUT_COUNT_W-1:0];
                  rsp_last_in  = (32'(rot_cnt_ff) + 32'd1 == 32'(active_lim));
               end
               if (turn_done) begin
                  state_in   = iohist_pkg::ST_IDLE;
                  rot_cnt_in = '0;
               end else begin
                  rot_cnt_in = rot_cnt_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in   = iohist_pkg::ST_IDLE;
            rot_cnt_in = '0;
         end
      endcase
   end

   assign active_in = (csr_if.valid && csr_if.ready) ? csr_if.data : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iohist_pkg::ST_IDLE;
         rot_cnt_ff   <= '0;
         active_ff    <= iohist_pkg::ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_cnt_ff   <= rot_cnt_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.out_index      = rsp_index_ff;
   assign rsp_if.out_low_bound  = rsp_low_ff;
   assign rsp_if.out_high_bound = rsp_high_ff;
   assign rsp_if.out_count      = rsp_count_ff;
   assign rsp_if.last           = rsp_last_ff;

   `IOHIST_ASSERT(a_readout_starts, clock, reset, (req_take && (req_if.op == iohist_pkg::OP_READOUT)) |=> (state_ff == iohist_pkg::ST_READ), "readout request did not start a turn")
   `IOHIST_NEVER(a_idle_cnt_clear, clock, reset, (state_ff == iohist_pkg::ST_IDLE) && (rot_cnt_ff != '0), "turn counter not clear while idle")
   `IOHIST_ASSERT(a_full_turn, clock, reset, $fell(state_ff == iohist_pkg::ST_READ) |-> (32'($past(rot_cnt_ff)) == 32'(NUM_BUCKETS - 1)), "readout left before a full turn")
   `IOHIST_ASSERT(a_last_index, clock, reset, (step && emit && (32'(rot_cnt_ff) + 32'd1 == 32'(active_lim))) |=> (rsp_if.valid && rsp_if.last), "final bucket not flagged")

endmodule

// ===== sim/interval_overlap_histogram_core_test.sv =====
module interval_overlap_histogram_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import iohist_pkg::*;

   localparam int  BUCKETS          = NUM_BUCKETS_DEF;
   localparam real PERIOD           = 12.0;
   localparam int  RESET_CYCLES     = 12;
   localparam int  DRAIN_CYCLES     = 2 * BUCKETS + 8;
   localparam int  RANDOM_PER_PHASE = 71;
   localparam int  HOLD_AT_REQUEST  = 150;
   localparam int  HOLD_CYCLES      = 300;
   localparam int  QUIET_FROM       = 250;
   localparam int  QUIET_TO         = 320;
   localparam int  LIMIT_CYCLES     = 500000;

   localparam logic signed [BOUND_W-1:0] BOUND_MIN = 32'sh8000_0000;
   localparam logic signed [BOUND_W-1:0] BOUND_MAX = 32'sh7FFF_FFFF;
   localparam logic [WEIGHT_W-1:0]       WEIGHT_MAX = '1;

   typedef struct {
      op_type                     op;
      logic [INDEX_W-1:0]         bucket_index;
      logic signed [BOUND_W-1:0]  range_low;
      logic signed [BOUND_W-1:0]  range_high;
      logic [WEIGHT_W-1:0]        weight;
      logic                       is_null;
   } hist_request_type;

   typedef struct {
      logic [INDEX_W-1:0]         index;
      logic signed [BOUND_W-1:0]  low_bound;
      logic signed [BOUND_W-1:0]  high_bound;
      logic [OUT_COUNT_W-1:0]     count;
      logic                       last;
   } bucket_readout_type;

   class histogram_scoreboard_type;
      logic signed [BOUND_W-1:0] low_bound [BUCKETS];
      logic signed [BOUND_W-1:0] high_bound [BUCKETS];
      logic [OUT_COUNT_W-1:0]    count [BUCKETS];
      logic [ACTIVE_W-1:0]       active_reg;
      bucket_readout_type        pending [$];
      int                        errors;
      int                        results_seen;
      int                        readouts;

      function new();
         foreach (count[i]) begin
            low_bound[i]  = '0;
            high_bound[i] = '0;
            count[i]      = '0;
         end
         active_reg   = ACTIVE_RESET;
         errors       = 0;
         results_seen = 0;
         readouts     = 0;
      endfunction

      function void set_active(logic [ACTIVE_W-1:0] value);
         active_reg = value;
      endfunction

      function logic [OUT_COUNT_W-1:0] sat_add(logic [OUT_COUNT_W-1:0] a,
                                               logic [WEIGHT_W-1:0] b);
         logic [OUT_COUNT_W:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[OUT_COUNT_W] ? '1 : sum[OUT_COUNT_W-1:0];
      endfunction

      function void note_request(hist_request_type r);
         int                 n;
         bucket_readout_type e;
         n = (active_reg > BUCKETS) ? BUCKETS : int'(active_reg);
         case (r.op)
            OP_LOAD: begin
               low_bound[r.bucket_index]  = r.range_low;
               high_bound[r.bucket_index] = r.range_high;
               count[r.bucket_index]      = '0;
            end
            OP_OBSERVE: begin
               if (!r.is_null) begin
                  for (int i = 0; i < n; i++) begin
                     if (r.range_low <= high_bound[i] && r.range_high >= low_bound[i])
                        count[i] = sat_add(count[i], r.weight);
                  end
               end
            end
            OP_MERGE: begin
               count[r.bucket_index] = sat_add(count[r.bucket_index], r.weight);
            end
            default: begin
               readouts++;
               for (int i = 0; i < n; i++) begin
                  e.index      = i[INDEX_W-1:0];
                  e.low_bound  = low_bound[i];
                  e.high_bound = high_bound[i];
                  e.count      = count[i];
                  e.last       = (i == n - 1);
                  pending.push_back(e);
               end
            end
         endcase
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_result(bucket_readout_type got);
         bucket_readout_type want;
         results_seen++;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected readout of bucket %0d", got.index));
            return;
         end
         want = pending.pop_front();
         if (got.index !== want.index)
            report_mismatch($sformatf("index got %0d want %0d", got.index, want.index));
         if (got.low_bound !== want.low_bound)
            report_mismatch($sformatf("bucket %0d low got %0d want %0d",
                                      want.index, got.low_bound, want.low_bound));
         if (got.high_bound !== want.high_bound)
            report_mismatch($sformatf("bucket %0d high got %0d want %0d",
                                      want.index, got.high_bound, want.high_bound));
         if (got.count !== want.count)
            report_mismatch($sformatf("bucket %0d count got %0h want %0h",
                                      want.index, got.count, want.count));
         if (got.last !== want.last)
            report_mismatch($sformatf("bucket %0d last got %b want %b",
                                      want.index, got.last, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   iohist_req_if req_bus ();
   iohist_rsp_if rsp_bus ();
   iohist_csr_if csr_bus ();

   interval_overlap_histogram_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   histogram_scoreboard_type sb = new();
   int                       accepted_requests = 0;
   int                       config_writes = 0;
   bucket_readout_type       observed;

   always #(PERIOD / 2.0) clock = ~clock;

   function automatic bit quiet_window();
      return accepted_requests >= QUIET_FROM && accepted_requests < QUIET_TO;
   endfunction

   function automatic hist_request_type make_request(op_type op, int idx,
                                                     logic signed [BOUND_W-1:0] lo,
                                                     logic signed [BOUND_W-1:0] hi,
                                                     logic [WEIGHT_W-1:0] w, logic nul);
      hist_request_type r;
      r.op           = op;
      r.bucket_index = idx[INDEX_W-1:0];
      r.range_low    = lo;
      r.range_high   = hi;
      r.weight       = w;
      r.is_null      = nul;
      return r;
   endfunction

   function automatic hist_request_type random_request();
      hist_request_type r;
      int               pick;
      int               base;
      pick = $urandom_range(99);
      if (pick < 25)
         r.op = OP_LOAD;
      else if (pick < 68)
         r.op = OP_OBSERVE;
      else if (pick < 84)
         r.op = OP_MERGE;
      else
         r.op = OP_READOUT;
      r.bucket_index = INDEX_W'($urandom_range(BUCKETS - 1));
      r.is_null = (r.op == OP_OBSERVE) ? ($urandom_range(99) < 15)
                                       : 1'($urandom_range(1));
      // mostly narrow ranges in a shared window so buckets and intervals overlap
      if ($urandom_range(99) < 80) begin
         base         = int'($urandom_range(400)) - 200;
         r.range_low  = base;
         r.range_high = base + int'($urandom_range(60)) - 10;
      end else begin
         r.range_low  = $urandom;
         r.range_high = $urandom;
      end
      case ($urandom_range(9))
         0:       r.weight = $urandom;
         1:       r.weight = WEIGHT_MAX - $urandom_range(3);
         default: r.weight = $urandom_range(500, 1);
      endcase
      return r;
   endfunction

   task automatic send_request(hist_request_type r);
      while (!quiet_window() && $urandom_range(99) < 31) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= r.op;
      req_bus.bucket_index <= r.bucket_index;
      req_bus.range_low    <= r.range_low;
      req_bus.range_high   <= r.range_high;
      req_bus.weight       <= r.weight;
      req_bus.is_null      <= r.is_null;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
      accepted_requests++;
   endtask

   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      // a readout with no active bucket leaves nothing queued but still runs
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(logic [ACTIVE_W-1:0] value);
      wait_until_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.set_active(value);
      config_writes++;
   endtask

   // result side: random back-pressure, one long hold-off, one quiet window
   initial begin
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!held && accepted_requests == HOLD_AT_REQUEST) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= quiet_window() || ($urandom_range(99) >= 31);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         observed.index      = rsp_bus.out_index;
         observed.low_bound  = rsp_bus.out_low_bound;
         observed.high_bound = rsp_bus.out_high_bound;
         observed.count      = rsp_bus.out_count;
         observed.last       = rsp_bus.last;
         sb.check_result(observed);
      end
   end

   initial begin
      logic [ACTIVE_W-1:0] phase_setting [5];

      req_bus.valid        = 1'b0;
      req_bus.op           = OP_LOAD;
      req_bus.bucket_index = '0;
      req_bus.range_low    = '0;
      req_bus.range_high   = '0;
      req_bus.weight       = '0;
      req_bus.is_null      = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.data         = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: table straight out of reset, then bound extremes
      send_request(make_request(OP_READOUT, 0, 0, 0, 0, 1'b0));
      send_request(make_request(OP_LOAD, 0, BOUND_MIN, BOUND_MAX, 0, 1'b0));
      send_request(make_request(OP_LOAD, 1, -10, 10, 0, 1'b0));
      send_request(make_request(OP_LOAD, 2, 100, 50, 0, 1'b0));   // inverted bucket
      send_request(make_request(OP_LOAD, 3, BOUND_MAX, BOUND_MAX, 0, 1'b0));
      send_request(make_request(OP_LOAD, 4, BOUND_MIN, BOUND_MIN, 0, 1'b1));
      send_request(make_request(OP_OBSERVE, 0, BOUND_MIN, BOUND_MIN, 1, 1'b0));
      send_request(make_request(OP_OBSERVE, 0, BOUND_MAX, BOUND_MAX, 2, 1'b0));
      send_request(make_request(OP_OBSERVE, 9, 0, 0, WEIGHT_MAX, 1'b0));
      send_request(make_request(OP_OBSERVE, 0, 40, 120, 7, 1'b0));
      send_request(make_request(OP_OBSERVE, 0, BOUND_MIN, BOUND_MAX, 1000, 1'b1));
      send_request(make_request(OP_OBSERVE, 0, 20, -20, 3, 1'b0)); // inverted interval
      send_request(make_request(OP_MERGE, 1, 0, 0, WEIGHT_MAX, 1'b0));
      send_request(make_request(OP_MERGE, 3, 0, 0, 9, 1'b1));
      send_request(make_request(OP_LOAD, 15, 1, 2, 0, 1'b1));
      send_request(make_request(OP_READOUT, 0, 0, 0, 0, 1'b1));

      // bucket written while outside the active set
      write_active(5'd4);
      send_request(make_request(OP_LOAD, 10, 0, 0, 0, 1'b0));
      send_request(make_request(OP_MERGE, 10, 0, 0, 5, 1'b0));
      send_request(make_request(OP_OBSERVE, 0, 0, 0, 1, 1'b0));
      send_request(make_request(OP_READOUT, 0, 0, 0, 0, 1'b0));

      // no active bucket: observe is a no-op, readout is empty
      write_active(5'd0);
      send_request(make_request(OP_OBSERVE, 0, BOUND_MIN, BOUND_MAX, 1, 1'b0));
      send_request(make_request(OP_READOUT, 0, 0, 0, 0, 1'b0));

      // setting above the table size clamps to the table
      write_active(5'd31);
      send_request(make_request(OP_READOUT, 0, 0, 0, 0, 1'b0));

      phase_setting = '{5'd1, 5'd16, 5'd17, 5'd8, 5'($urandom_range(31))};
      foreach (phase_setting[p]) begin
         write_active(phase_setting[p]);
         repeat (RANDOM_PER_PHASE) send_request(random_request());
      end

      wait_until_drained();
      $display("covered %0d requests, %0d readouts, %0d buckets read, %0d csr writes",
               accepted_requests, sb.readouts, sb.results_seen, config_writes);
      if (sb.errors == 0) begin
         $display("** interval_overlap_histogram_core: PASSED **");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("** interval_overlap_histogram_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * PERIOD);
      $display("timeout with %0d readout entries outstanding", sb.pending.size());
      $display("** interval_overlap_histogram_core: FAILED **");
      $finish;
   end
endmodule
